// ===== rtl/core/sbm_pkg.sv =====
// Shared types and constants for the serial bank mapper.
// No dependencies; imported by the top level, the work RAM, the checker and the bench.
package sbm_pkg;

  localparam int WORK_RAM_DEPTH_DEF = 8192;
  localparam int OFFSET_W = 13;

  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 32;
  localparam int M_TUSER_W = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [1:0] {
    REQ_CPU_READ  = 2'd0,
    REQ_CPU_WRITE = 2'd1,
    REQ_PPU_READ  = 2'd2,
    REQ_PPU_WRITE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    TGT_CONTROL  = 2'd0,
    TGT_CHR_LOW  = 2'd1,
    TGT_CHR_HIGH = 2'd2,
    TGT_PRG      = 2'd3
  } target_t;

  typedef enum logic [1:0] {
    PRG_MODE_32K_A    = 2'd0,
    PRG_MODE_32K_B    = 2'd1,
    PRG_MODE_FIX_LOW  = 2'd2,
    PRG_MODE_FIX_HIGH = 2'd3
  } prg_mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANK_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_BANK_COUNT = 1'd1;

  localparam logic [4:0] CTRL_RESET       = 5'h1C;
  localparam logic [4:0] CTRL_FORCE_MODE  = 5'h0C;
  localparam logic [4:0] PRG_COUNT_RESET  = 5'd16;
  localparam logic [4:0] CHR_COUNT_RESET  = 5'd0;
  localparam logic [2:0] SHIFT_COMMIT_CNT = 3'd5;

  typedef struct packed {
    logic                we;
    logic                re;
    logic [OFFSET_W-1:0] offset;
    logic [7:0]          wdata;
  } ram_req_t;

endpackage

// ===== rtl/core/sbm_work_ram.sv =====
// Work RAM for the serial bank mapper: single-port synchronous array,
// offset-to-index folding and the post-reset clearing sweep. Uses sbm_pkg.
module sbm_work_ram #(
  parameter int DEPTH = sbm_pkg::WORK_RAM_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  sbm_pkg::ram_req_t req,
  output logic              busy,
  output logic [7:0]        rdata
);
  import sbm_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [15:0] DEPTH_W = 16'(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] clr_addr;
  logic [15:0]   fold;
  logic [AW-1:0] idx;

  // offset mod DEPTH; offset < 4 * DEPTH over the whole range
  always_comb begin
    fold = 16'(req.offset);
    for (int i = 0; i < 3; i++) begin
      if (fold >= DEPTH_W) begin
        fold = fold - DEPTH_W;
      end
    end
    idx = fold[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= 8'd0;
    end else if (req.we) begin
      mem[idx] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[idx];
    end
  end

endmodule

// ===== rtl/core/serial_bank_mapper.sv =====
// Serial-load bank mapper top level: access decode, bank registers,
// result pipeline. Uses sbm_pkg and sbm_work_ram.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata: addr, write_data; tuser: req_type
//  m_*      out  m_tvalid/m_tready  tdata: xlat_addr, read_data, mirror_mode;
//                                   tuser: hit, from_ram
//  cfg_*    in   cfg_we             cfg_index, cfg_data
//
// One item per cycle unless the RAM sweep or an output stall holds the input; a result
// item passes the work RAM read stage and then the output register before it is offered.
// Two result slots absorb output stalls.
// After reset the work RAM is swept to zero with s_tready low; configuration writes
// are taken throughout.
module serial_bank_mapper #(
  parameter int WORK_RAM_DEPTH = sbm_pkg::WORK_RAM_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [sbm_pkg::S_TDATA_W-1:0]    s_tdata,   // addr[15:0], write_data[23:16]
  input  logic [sbm_pkg::S_TUSER_W-1:0]    s_tuser,   // req_type[1:0]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [sbm_pkg::M_TDATA_W-1:0]    m_tdata,   // xlat_addr[17:0], read_data[25:18],
                                                      // mirror_mode[27:26], zero[31:28]
  output logic [sbm_pkg::M_TUSER_W-1:0]    m_tuser,   // hit[0], from_ram[1]
  input  logic                             cfg_we,
  input  logic [sbm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sbm_pkg::*;

  logic [4:0] prg_bank_count, chr_bank_count;
  logic [4:0] shift_value, shift_value_next;
  logic [2:0] shift_count, shift_count_next;
  logic [4:0] control_bits, control_bits_next;
  logic [4:0] chr_low_bank, chr_low_bank_next;
  logic [4:0] chr_high_bank, chr_high_bank_next;
  logic [3:0] chr_whole_bank, chr_whole_bank_next;
  logic [2:0] prg_whole_bank, prg_whole_bank_next;
  logic [3:0] prg_low_bank, prg_low_bank_next;
  logic [3:0] prg_high_bank, prg_high_bank_next;
  logic [1:0] mirror_state, mirror_state_next;

  logic        acc, ram_busy;
  req_t        req;
  logic [15:0] a;
  logic [7:0]  d;
  logic        in_wram, in_rom, in_chr;
  logic        hit_c, ram_c, rsel_c;
  logic [17:0] mapped_c;
  logic [4:0]  shifted, v;
  logic [2:0]  count_inc;
  logic [3:0]  prg_last;
  ram_req_t    ram_req;
  logic [7:0]  ram_q;

  logic        s1_valid, s1_hit, s1_ram, s1_rsel;
  logic [17:0] s1_mapped;
  logic [1:0]  s1_mirror;
  logic        s1_adv;
  logic        out_valid, out_hit, out_ram;
  logic [17:0] out_mapped;
  logic [7:0]  out_rdata;
  logic [1:0]  out_mirror;

  assign req = req_t'(s_tuser);
  assign a   = s_tdata[15:0];
  assign d   = s_tdata[23:16];

  assign in_wram = (a[15:13] == 3'b011);
  assign in_rom  = a[15];
  assign in_chr  = (a[15:13] == 3'b000);

  assign s1_adv   = s1_valid && (!out_valid || m_tready);
  assign s_tready = !ram_busy && (!s1_valid || s1_adv);
  assign acc      = s_tvalid && s_tready;

  always_comb begin
    hit_c    = 1'b0;
    ram_c    = 1'b0;
    rsel_c   = 1'b0;
    mapped_c = '0;
    case (req)
      REQ_CPU_READ: begin
        if (in_wram) begin
          hit_c  = 1'b1;
          ram_c  = 1'b1;
          rsel_c = 1'b1;
        end else if (in_rom) begin
          hit_c = 1'b1;
          if (control_bits[3]) begin
            mapped_c = {(a[14] ? prg_high_bank : prg_low_bank), a[13:0]};
          end else begin
            mapped_c = {prg_whole_bank, a[14:0]};
          end
        end
      end
      REQ_CPU_WRITE: begin
        if (in_wram) begin
          hit_c = 1'b1;
          ram_c = 1'b1;
        end
      end
      REQ_PPU_READ: begin
        if (in_chr) begin
          hit_c = 1'b1;
          if (chr_bank_count == 5'd0) begin
            mapped_c = {5'd0, a[12:0]};
          end else if (control_bits[4]) begin
            mapped_c = {1'b0, (a[12] ? chr_high_bank : chr_low_bank), a[11:0]};
          end else begin
            mapped_c = {1'b0, chr_whole_bank, a[12:0]};
          end
        end
      end
      REQ_PPU_WRITE: begin
        if (in_chr) begin
          hit_c = 1'b1;
          if (chr_bank_count == 5'd0) begin
            mapped_c = {5'd0, a[12:0]};
          end
        end
      end
      default: begin
        hit_c = 1'b0;
      end
    endcase
  end

  assign shifted   = {d[0], shift_value[4:1]};
  assign count_inc = shift_count + 3'd1;
  assign v         = shifted;
  assign prg_last  = 4'(prg_bank_count - 5'd1);

  always_comb begin
    shift_value_next    = shift_value;
    shift_count_next    = shift_count;
    control_bits_next   = control_bits;
    chr_low_bank_next   = chr_low_bank;
    chr_high_bank_next  = chr_high_bank;
    chr_whole_bank_next = chr_whole_bank;
    prg_whole_bank_next = prg_whole_bank;
    prg_low_bank_next   = prg_low_bank;
    prg_high_bank_next  = prg_high_bank;
    mirror_state_next   = mirror_state;
    if (acc && req == REQ_CPU_WRITE && in_rom) begin
      if (d[7]) begin
        shift_value_next  = '0;
        shift_count_next  = '0;
        control_bits_next = control_bits | CTRL_FORCE_MODE;
      end else if (count_inc == SHIFT_COMMIT_CNT) begin
        shift_value_next = '0;
        shift_count_next = '0;
        case (target_t'(a[14:13]))
          TGT_CONTROL: begin
            control_bits_next = v;
            mirror_state_next = v[1:0];
          end
          TGT_CHR_LOW: begin
            if (control_bits[4]) begin
              chr_low_bank_next = v;
            end else begin
              chr_whole_bank_next = v[4:1];
            end
          end
          TGT_CHR_HIGH: begin
            if (control_bits[4]) begin
              chr_high_bank_next = v;
            end
          end
          TGT_PRG: begin
            case (prg_mode_t'(control_bits[3:2]))
              PRG_MODE_32K_A, PRG_MODE_32K_B: begin
                prg_whole_bank_next = v[3:1];
              end
              PRG_MODE_FIX_LOW: begin
                prg_low_bank_next  = '0;
                prg_high_bank_next = v[3:0];
              end
              PRG_MODE_FIX_HIGH: begin
                prg_low_bank_next  = v[3:0];
                prg_high_bank_next = prg_last;
              end
              default: begin
                prg_low_bank_next = prg_low_bank;
              end
            endcase
          end
          default: begin
            control_bits_next = control_bits;
          end
        endcase
      end else begin
        shift_value_next = shifted;
        shift_count_next = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count <= PRG_COUNT_RESET;
      chr_bank_count <= CHR_COUNT_RESET;
      shift_value    <= '0;
      shift_count    <= '0;
      control_bits   <= CTRL_RESET;
      chr_low_bank   <= '0;
      chr_high_bank  <= '0;
      chr_whole_bank <= '0;
      prg_whole_bank <= '0;
      prg_low_bank   <= '0;
      prg_high_bank  <= 4'(PRG_COUNT_RESET - 5'd1);
      mirror_state   <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_PRG_BANK_COUNT) begin
        prg_bank_count <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_CHR_BANK_COUNT) begin
        chr_bank_count <= cfg_data;
      end
      shift_value    <= shift_value_next;
      shift_count    <= shift_count_next;
      control_bits   <= control_bits_next;
      chr_low_bank   <= chr_low_bank_next;
      chr_high_bank  <= chr_high_bank_next;
      chr_whole_bank <= chr_whole_bank_next;
      prg_whole_bank <= prg_whole_bank_next;
      prg_low_bank   <= prg_low_bank_next;
      prg_high_bank  <= prg_high_bank_next;
      mirror_state   <= mirror_state_next;
    end
  end

  always_comb begin
    ram_req.we     = acc && req == REQ_CPU_WRITE && in_wram;
    ram_req.re     = acc && rsel_c;
    ram_req.offset = a[OFFSET_W-1:0];
    ram_req.wdata  = d;
  end

  sbm_work_ram #(
    .DEPTH(WORK_RAM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .rst  (rst),
    .req  (ram_req),
    .busy (ram_busy),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_hit    <= hit_c;
      s1_ram    <= ram_c;
      s1_rsel   <= rsel_c;
      s1_mapped <= mapped_c;
      s1_mirror <= mirror_state_next;
    end
    if (s1_adv) begin
      out_hit    <= s1_hit;
      out_ram    <= s1_ram;
      out_mapped <= s1_mapped;
      out_rdata  <= s1_rsel ? ram_q : 8'd0;
      out_mirror <= s1_mirror;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, out_mirror, out_rdata, out_mapped};
  assign m_tuser  = {out_ram, out_hit};

endmodule

// ===== rtl/core/sbm_checker.sv =====
// Port-level checks for serial_bank_mapper, attached by bind.
// Uses sbm_pkg for port widths.
module sbm_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [sbm_pkg::M_TDATA_W-1:0]    m_tdata,
  input logic [sbm_pkg::M_TUSER_W-1:0]    m_tuser
);
  import sbm_pkg::*;

  // RAM sweep holds off input right after reset
  a_clear_holds: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input accepted during work RAM clear");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_ram_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0])
    else $error("work RAM result without hit");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[25:0] == 26'd0)
    else $error("unclaimed access carries address or data");

  a_rdata_ram: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> m_tdata[25:18] == 8'd0 && m_tdata[31:28] == 4'd0)
    else $error("read data outside work RAM");

endmodule

bind serial_bank_mapper sbm_checker u_sbm_checker (.*);

// ===== verif/testbench.sv =====
// Self-checking bench for serial_bank_mapper: directed table, then random bus accesses.
// An in-bench model of the mapper predicts the result items; typed directed rows carry their own.
// The phases change the bank counts and the amount of idling on the input and output sides.
module testbench;
  import sbm_pkg::*;

  localparam int WRAM_DEPTH   = WORK_RAM_DEPTH_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 200;
  localparam int NUM_PHASES   = 8;

  typedef enum int {FLOW_FREE, FLOW_SEND_IDLE, FLOW_RECV_STALL, FLOW_BOTH} flow_t;

  typedef struct packed {
    logic        hit;
    logic        from_ram;
    logic [17:0] xlat_addr;
    logic [7:0]  read_data;
    logic [1:0]  mirror_mode;
  } access_result_t;

  typedef struct {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_value;
    req_t                  req;
    logic [15:0]           addr;
    logic [7:0]            data;
    logic                  typed;
    access_result_t        result;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;   // addr[15:0], write_data[23:16]
  logic [S_TUSER_W-1:0]  s_tuser = '0;   // req_type[1:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;        // xlat_addr[17:0], read_data[25:18], mirror_mode[27:26]
  logic [M_TUSER_W-1:0]  m_tuser;        // hit[0], from_ram[1]
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  serial_bank_mapper dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // mapper model state
  logic [4:0] prg_count, chr_count;
  logic [4:0] sr_value;
  logic [2:0] sr_count;
  logic [4:0] ctrl;
  logic [4:0] chr_lo, chr_hi;
  logic [3:0] chr_8k;
  logic [2:0] prg_32k;
  logic [3:0] prg_lo, prg_hi;
  logic [1:0] mirror;
  logic [7:0] wram [WRAM_DEPTH];

  access_result_t pending_results[$];
  stim_row_t      directed[$];
  int             failures = 0;
  int             items_sent = 0;
  int             cycle_count = 0;
  flow_t          flow_mode = FLOW_FREE;
  logic           hold_req = 1'b0;
  logic           hold_done = 1'b0;
  int             hold_left = 0;

  int phase_prg[NUM_PHASES] = '{16, 1, 2, 16, 0, 5, 31, 1};
  int phase_chr[NUM_PHASES] = '{0, 16, 1, 16, 31, 8, 3, 0};

  function automatic access_result_t predict_access(req_t r, logic [15:0] a, logic [7:0] d);
    access_result_t res;
    logic [4:0] v;
    logic [3:0] bank;
    res = '0;
    case (r)
      REQ_CPU_READ: begin
        if (a >= 16'h6000 && a <= 16'h7FFF) begin
          res.hit = 1'b1;
          res.from_ram = 1'b1;
          res.read_data = wram[int'(a[12:0]) % WRAM_DEPTH];
        end else if (a >= 16'h8000) begin
          res.hit = 1'b1;
          if (ctrl[3]) begin
            bank = (a <= 16'hBFFF) ? prg_lo : prg_hi;
            res.xlat_addr = {bank, a[13:0]};
          end else begin
            res.xlat_addr = {prg_32k, a[14:0]};
          end
        end
      end
      REQ_CPU_WRITE: begin
        if (a >= 16'h6000 && a <= 16'h7FFF) begin
          res.hit = 1'b1;
          res.from_ram = 1'b1;
          wram[int'(a[12:0]) % WRAM_DEPTH] = d;
        end else if (a >= 16'h8000) begin
          if (d[7]) begin
            sr_value = '0;
            sr_count = '0;
            ctrl = ctrl | CTRL_FORCE_MODE;
          end else begin
            sr_value = {d[0], sr_value[4:1]};
            sr_count = sr_count + 3'd1;
            if (sr_count == SHIFT_COMMIT_CNT) begin
              v = sr_value;
              case (target_t'(a[14:13]))
                TGT_CONTROL: begin
                  ctrl = v;
                  mirror = v[1:0];
                end
                TGT_CHR_LOW: begin
                  if (ctrl[4]) chr_lo = v;
                  else chr_8k = v[4:1];
                end
                TGT_CHR_HIGH: begin
                  if (ctrl[4]) chr_hi = v;
                end
                default: begin
                  case (prg_mode_t'(ctrl[3:2]))
                    PRG_MODE_32K_A, PRG_MODE_32K_B: prg_32k = v[3:1];
                    PRG_MODE_FIX_LOW: begin
                      prg_lo = '0;
                      prg_hi = v[3:0];
                    end
                    default: begin
                      prg_lo = v[3:0];
                      prg_hi = 4'(prg_count - 5'd1);
                    end
                  endcase
                end
              endcase
              sr_value = '0;
              sr_count = '0;
            end
          end
        end
      end
      REQ_PPU_READ: begin
        if (a < 16'h2000) begin
          res.hit = 1'b1;
          if (chr_count == 5'd0) res.xlat_addr = {5'd0, a[12:0]};
          else if (ctrl[4]) res.xlat_addr = {1'b0, (a[12] ? chr_hi : chr_lo), a[11:0]};
          else res.xlat_addr = {1'b0, chr_8k, a[12:0]};
        end
      end
      default: begin
        if (a < 16'h2000) begin
          res.hit = 1'b1;
          if (chr_count == 5'd0) res.xlat_addr = {5'd0, a[12:0]};
        end
      end
    endcase
    res.mirror_mode = mirror;
    return res;
  endfunction

  function automatic stim_row_t item_row(req_t r, logic [15:0] a, logic [7:0] d);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.cfg_index = '0;
    row.cfg_value = '0;
    row.req = r;
    row.addr = a;
    row.data = d;
    row.typed = 1'b0;
    row.result = '0;
    return row;
  endfunction

  function automatic stim_row_t typed_row(req_t r, logic [15:0] a, logic [7:0] d, logic hit,
                                          logic ram, logic [17:0] maddr, logic [7:0] rd,
                                          logic [1:0] mir);
    stim_row_t row;
    row = item_row(r, a, d);
    row.typed = 1'b1;
    row.result = {hit, ram, maddr, rd, mir};
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row = item_row(REQ_CPU_READ, '0, '0);
    row.is_cfg = 1'b1;
    row.cfg_index = idx;
    row.cfg_value = val;
    return row;
  endfunction

  // five serial writes, low bit first; the last address picks the register
  task automatic add_load(logic [15:0] a, logic [4:0] v);
    for (int i = 0; i < 5; i++) directed.push_back(item_row(REQ_CPU_WRITE, a, {7'd0, v[i]}));
  endtask

  task automatic send_access(stim_row_t row);
    access_result_t predicted;
    int idle_pct;
    idle_pct = (flow_mode == FLOW_SEND_IDLE) ? 82 : (flow_mode == FLOW_BOTH) ? 29 : 0;
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {row.data, row.addr};
    s_tuser <= row.req;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = predict_access(row.req, row.addr, row.data);
    pending_results.push_back(row.typed ? row.result : predicted);
    items_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PRG_BANK_COUNT) prg_count = val;
    else chr_count = val;
    @(posedge clk);
  endtask

  task automatic send_random_group();
    int pick;
    int cut;
    logic broken;
    logic [1:0] tgt;
    logic [4:0] v;
    logic [12:0] off;
    pick = $urandom_range(99);
    if (pick < 35) begin
      tgt = 2'($urandom);
      v = 5'($urandom);
      broken = ($urandom_range(9) == 0);
      cut = $urandom_range(4, 1);
      if ($urandom_range(3) == 0)
        send_access(item_row(REQ_CPU_WRITE, {1'b1, 15'($urandom)}, {1'b1, 7'($urandom)}));
      for (int i = 0; i < 5; i++) begin
        if (broken && i == cut)
          send_access(item_row(REQ_CPU_WRITE, {1'b1, 15'($urandom)}, {1'b1, 7'($urandom)}));
        send_access(item_row(REQ_CPU_WRITE,
                             {1'b1, (i == 4) ? tgt : 2'($urandom), 13'($urandom)},
                             {1'b0, 6'($urandom), v[i]}));
        if ($urandom_range(4) == 0)
          send_access(item_row($urandom_range(1) ? REQ_CPU_READ : REQ_PPU_READ,
                               16'($urandom), 8'($urandom)));
      end
    end else if (pick < 50) begin
      send_access(item_row(REQ_CPU_READ, {1'b1, 15'($urandom)}, 8'($urandom)));
    end else if (pick < 65) begin
      off = $urandom_range(1) ? 13'($urandom_range(15)) : 13'($urandom);
      send_access(item_row($urandom_range(1) ? REQ_CPU_WRITE : REQ_CPU_READ,
                           {3'b011, off}, 8'($urandom)));
    end else if (pick < 82) begin
      send_access(item_row($urandom_range(1) ? REQ_PPU_WRITE : REQ_PPU_READ,
                           {3'b000, 13'($urandom)}, 8'($urandom)));
    end else begin
      send_access(item_row(req_t'($urandom_range(3)), 16'($urandom), 8'($urandom)));
    end
  endtask

  function automatic void check_field(string name, logic [17:0] want, logic [17:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  // output side: checks accepted items, drives m_tready
  always @(posedge clk) begin
    access_result_t want;
    if (m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: tdata %0h tuser %0h", m_tdata, m_tuser);
        failures++;
      end else begin
        want = pending_results.pop_front();
        check_field("hit", want.hit, m_tuser[0]);
        check_field("from_ram", want.from_ram, m_tuser[1]);
        check_field("xlat_addr", want.xlat_addr, m_tdata[17:0]);
        check_field("read_data", want.read_data, m_tdata[25:18]);
        check_field("mirror_mode", want.mirror_mode, m_tdata[27:26]);
      end
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= $urandom_range(99) >= ((flow_mode == FLOW_RECV_STALL) ? 82 :
                                         (flow_mode == FLOW_BOTH) ? 29 : 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL serial_bank_mapper");
      $finish;
    end
  end

  initial begin
    int start;
    prg_count = PRG_COUNT_RESET;
    chr_count = CHR_COUNT_RESET;
    sr_value = '0;
    sr_count = '0;
    ctrl = CTRL_RESET;
    chr_lo = '0;
    chr_hi = '0;
    chr_8k = '0;
    prg_32k = '0;
    prg_lo = '0;
    prg_hi = 4'(prg_count - 5'd1);
    mirror = '0;
    foreach (wram[i]) wram[i] = '0;

    directed.push_back(typed_row(REQ_CPU_READ, 16'hC000, 8'h00, 1, 0, 18'h3C000, 8'h00, 2'd0));
    directed.push_back(typed_row(REQ_CPU_READ, 16'hFFFF, 8'hFF, 1, 0, 18'h3FFFF, 8'h00, 2'd0));
    directed.push_back(typed_row(REQ_CPU_READ, 16'h5FFF, 8'hFF, 0, 0, 18'h0, 8'h00, 2'd0));
    directed.push_back(typed_row(REQ_CPU_WRITE, 16'h7FFF, 8'hFF, 1, 1, 18'h0, 8'h00, 2'd0));
    directed.push_back(typed_row(REQ_CPU_READ, 16'h7FFF, 8'h00, 1, 1, 18'h0, 8'hFF, 2'd0));
    directed.push_back(typed_row(REQ_PPU_READ, 16'h1FFF, 8'h00, 1, 0, 18'h1FFF, 8'h00, 2'd0));
    directed.push_back(typed_row(REQ_PPU_WRITE, 16'h2000, 8'hFF, 0, 0, 18'h0, 8'h00, 2'd0));
    add_load(16'h8000, 5'h03);   // horizontal, 32K PRG, 8K CHR
    add_load(16'hA000, 5'h1F);   // 8K CHR select drops bit 0
    add_load(16'hC000, 5'h15);   // CHR high ignored in 8K mode
    directed.push_back(cfg_row(CFG_CHR_BANK_COUNT, 5'd16));
    directed.push_back(item_row(REQ_PPU_READ, 16'h1ABC, 8'h00));
    // write to pattern ROM: claimed, no address
    directed.push_back(typed_row(REQ_PPU_WRITE, 16'h0010, 8'h5A, 1, 0, 18'h0, 8'h00, 2'd3));
    directed.push_back(typed_row(REQ_CPU_WRITE, 16'hE000, 8'h80, 0, 0, 18'h0, 8'h00, 2'd3));
    directed.push_back(item_row(REQ_CPU_READ, 16'h8000, 8'h00));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        wait_idle();
        write_reg(directed[i].cfg_index, directed[i].cfg_value);
      end else begin
        send_access(directed[i]);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_reg(CFG_PRG_BANK_COUNT, 5'(phase_prg[p]));
      write_reg(CFG_CHR_BANK_COUNT, 5'(phase_chr[p]));
      flow_mode <= flow_t'(p % 4);
      if (p == 4) hold_req <= 1'b1;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) send_random_group();
    end

    wait_idle();
    if (failures == 0) $display("PASS serial_bank_mapper");
    else $display("FAIL serial_bank_mapper");
    $finish;
  end

endmodule
